[src/ray_box_slab_test_macros.svh]
// Assertion helpers for the ray/box slab test block.
`ifndef RAY_BOX_SLAB_TEST_MACROS_SVH
`define RAY_BOX_SLAB_TEST_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define RBST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ray_box_slab_test: assertion failed");
// Check a property on every clock edge, reset included.
`define RBST_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("ray_box_slab_test: assertion failed during reset");
`else
`define RBST_ASSERT(lbl, prop)
`define RBST_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[src/rbst_pkg.sv]
`default_nettype none
package rbst_pkg;
  // Quotient bits produced by the divider, one per stage.
  localparam int QW = 32;
  // Divider: magnitude stage, QW+1 iteration registers, output stage.
  localparam int DIV_LAT = QW + 3;
  // Lane: offset stage, divider, sort stage.
  localparam int LANE_LAT = DIV_LAT + 2;
  // Through the near/far merge stage.
  localparam int PIPE_LAT = LANE_LAT + 1;

  localparam int NUM_AXES = 3;
  localparam int CFG_IW = 3;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IW-1:0] {
    REG_LOW_X  = 3'd0,
    REG_LOW_Y  = 3'd1,
    REG_LOW_Z  = 3'd2,
    REG_HIGH_X = 3'd3,
    REG_HIGH_Y = 3'd4,
    REG_HIGH_Z = 3'd5
  } cfg_reg_e;
endpackage
`default_nettype wire

[src/rbst_div.sv]
`default_nettype none
// Pipelined signed Q16.16 divide (offset << 16) / dir, truncating and saturating.
module rbst_div #(
  parameter bit FaceHigh = 1'b0
) (
  input  wire logic               clk_i,
  input  wire logic               adv_i,
  input  wire logic signed [32:0] off_i,
  input  wire logic signed [31:0] dir_i,
  output logic signed [31:0]      quot_o
);
  localparam int QW = rbst_pkg::QW;

  logic [32:0]        off_neg;
  logic [31:0]        off_mag;
  logic [31:0]        dir_mag;
  logic               spec_d;
  logic signed [31:0] specv_d;

  logic [47:0]        nmag_q;
  logic [31:0]        dmag_q;
  logic               neg_q, spec_q;
  logic signed [31:0] specv_q;

  logic [31:0]        r_q    [0:QW];
  logic [31:0]        lo_q   [0:QW];
  logic [31:0]        q_q    [0:QW];
  logic [31:0]        d_q    [0:QW];
  logic               neg_a  [0:QW];
  logic               spec_a [0:QW];
  logic               ovf_a  [0:QW];
  logic signed [31:0] specv_a[0:QW];

  logic signed [31:0] quot_d;
  logic signed [31:0] quot_q;

  always_comb begin
    off_neg = 33'd0 - off_i;
    off_mag = off_i[32] ? off_neg[31:0] : off_i[31:0];
    dir_mag = dir_i[31] ? (32'd0 - dir_i) : dir_i;
    spec_d  = (dir_i == 32'sd0);
    if (off_i > 33'sd0) begin
      specv_d = rbst_pkg::Q_MAX;
    end else if (off_i < 33'sd0) begin
      specv_d = rbst_pkg::Q_MIN;
    end else begin
      specv_d = FaceHigh ? rbst_pkg::Q_MAX : rbst_pkg::Q_MIN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      nmag_q  <= {off_mag, 16'd0};
      dmag_q  <= dir_mag;
      neg_q   <= off_i[32] ^ dir_i[31];
      spec_q  <= spec_d;
      specv_q <= specv_d;
      // Quotient at or above 2^32 when the top part reaches the divisor.
      r_q[0]     <= {16'd0, nmag_q[47:32]};
      lo_q[0]    <= nmag_q[31:0];
      q_q[0]     <= 32'd0;
      d_q[0]     <= dmag_q;
      neg_a[0]   <= neg_q;
      spec_a[0]  <= spec_q;
      ovf_a[0]   <= ({16'd0, nmag_q[47:32]} >= dmag_q);
      specv_a[0] <= specv_q;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;
    always_comb begin
      trial = {r_q[k], lo_q[k][31]};
      diff  = trial - {1'b0, d_q[k]};
      ge    = (trial >= {1'b0, d_q[k]});
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        r_q[k+1]     <= ge ? diff[31:0] : trial[31:0];
        lo_q[k+1]    <= {lo_q[k][30:0], 1'b0};
        q_q[k+1]     <= {q_q[k][30:0], ge};
        d_q[k+1]     <= d_q[k];
        neg_a[k+1]   <= neg_a[k];
        spec_a[k+1]  <= spec_a[k];
        ovf_a[k+1]   <= ovf_a[k];
        specv_a[k+1] <= specv_a[k];
      end
    end
  end

  always_comb begin
    if (spec_a[QW]) begin
      quot_d = specv_a[QW];
    end else if (ovf_a[QW]) begin
      quot_d = neg_a[QW] ? rbst_pkg::Q_MIN : rbst_pkg::Q_MAX;
    end else if (neg_a[QW]) begin
      quot_d = (q_q[QW] > 32'h8000_0000) ? rbst_pkg::Q_MIN : (32'sd0 - q_q[QW]);
    end else begin
      quot_d = q_q[QW][31] ? rbst_pkg::Q_MAX : q_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;
endmodule
`default_nettype wire

[src/rbst_lane.sv]
`default_nettype none
// One axis: face offsets, two dividers, near/far sort.
module rbst_lane (
  input  wire logic               clk_i,
  input  wire logic               adv_i,
  input  wire logic signed [31:0] org_i,
  input  wire logic signed [31:0] dir_i,
  input  wire logic signed [31:0] lo_i,
  input  wire logic signed [31:0] hi_i,
  output logic signed [31:0]      t_in_o,
  output logic signed [31:0]      t_out_o
);
  logic signed [32:0] off_lo_q, off_hi_q;
  logic signed [31:0] dir_q;
  logic signed [31:0] t_lo, t_hi;
  logic signed [31:0] t_in_q, t_out_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      off_lo_q <= {lo_i[31], lo_i} - {org_i[31], org_i};
      off_hi_q <= {hi_i[31], hi_i} - {org_i[31], org_i};
      dir_q    <= dir_i;
    end
  end

  rbst_div #(.FaceHigh(1'b0)) u_div_lo (
    .clk_i (clk_i),
    .adv_i (adv_i),
    .off_i (off_lo_q),
    .dir_i (dir_q),
    .quot_o(t_lo)
  );

  rbst_div #(.FaceHigh(1'b1)) u_div_hi (
    .clk_i (clk_i),
    .adv_i (adv_i),
    .off_i (off_hi_q),
    .dir_i (dir_q),
    .quot_o(t_hi)
  );

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      t_in_q  <= (t_lo < t_hi) ? t_lo : t_hi;
      t_out_q <= (t_lo < t_hi) ? t_hi : t_lo;
    end
  end

  assign t_in_o  = t_in_q;
  assign t_out_o = t_out_q;
endmodule
`default_nettype wire

[src/ray_box_slab_test.sv]
// Pipeline from input transaction to result: offset, 35-stage divider, sort,
//   near/far merge, output register; one lane per axis, two dividers each.
// Throughput: one ray per cycle; the whole pipeline holds while the output stalls.
// Reset: asynchronous, active low; clears box registers to zero and all valid bits.
`default_nettype none
`include "ray_box_slab_test_macros.svh"
module ray_box_slab_test (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic signed [31:0]              origin_x_i,
  input  wire logic signed [31:0]              origin_y_i,
  input  wire logic signed [31:0]              origin_z_i,
  input  wire logic signed [31:0]              direction_x_i,
  input  wire logic signed [31:0]              direction_y_i,
  input  wire logic signed [31:0]              direction_z_i,
  input  wire logic signed [31:0]              best_distance_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 hit_o,
  output logic signed [31:0]                   new_best_distance_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [rbst_pkg::CFG_IW-1:0]     cfg_idx_i,
  input  wire logic [31:0]                     cfg_data_i
);
  localparam int NA = rbst_pkg::NUM_AXES;
  localparam int PL = rbst_pkg::PIPE_LAT;

  // Box corners: index 0..2 low x/y/z, 3..5 high x/y/z.
  logic signed [31:0] box_q [0:2*NA-1];

  logic signed [31:0] org [0:NA-1];
  logic signed [31:0] dir [0:NA-1];
  logic signed [31:0] t_in [0:NA-1];
  logic signed [31:0] t_out[0:NA-1];

  logic               v_q    [0:PL-1];
  logic signed [31:0] best_q [0:PL-1];
  logic signed [31:0] near_d, far_d, near_q, far_q;
  logic               adv;
  logic               out_valid_q, hit_q;
  logic signed [31:0] nbd_q;
  logic               hit_d;

  // Advance everything whenever the output register is free or being drained.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2*NA; i++) begin
        box_q[i] <= 32'sd0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbst_pkg::REG_LOW_X:  box_q[0] <= cfg_data_i;
        rbst_pkg::REG_LOW_Y:  box_q[1] <= cfg_data_i;
        rbst_pkg::REG_LOW_Z:  box_q[2] <= cfg_data_i;
        rbst_pkg::REG_HIGH_X: box_q[3] <= cfg_data_i;
        rbst_pkg::REG_HIGH_Y: box_q[4] <= cfg_data_i;
        rbst_pkg::REG_HIGH_Z: box_q[5] <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = direction_x_i;
  assign dir[1] = direction_y_i;
  assign dir[2] = direction_z_i;

  for (genvar a = 0; a < NA; a++) begin : g_lane
    rbst_lane u_lane (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .org_i  (org[a]),
      .dir_i  (dir[a]),
      .lo_i   (box_q[a]),
      .hi_i   (box_q[NA+a]),
      .t_in_o (t_in[a]),
      .t_out_o(t_out[a])
    );
  end

  // Valid and best distance ride alongside the lanes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PL; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (adv) begin
      v_q[0] <= in_valid_i;
      for (int i = 1; i < PL; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      best_q[0] <= best_distance_i;
      for (int i = 1; i < PL; i++) begin
        best_q[i] <= best_q[i-1];
      end
    end
  end

  // Merge: overall near is the largest entry, far the smallest exit.
  always_comb begin
    near_d = rbst_pkg::Q_MIN;
    far_d  = rbst_pkg::Q_MAX;
    for (int a = 0; a < NA; a++) begin
      if (t_in[a] > near_d) near_d = t_in[a];
      if (t_out[a] < far_d) far_d = t_out[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      near_q <= near_d;
      far_q  <= far_d;
    end
  end

  assign hit_d = (near_q < far_q) && (near_q < best_q[PL-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v_q[PL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q <= hit_d;
      nbd_q <= hit_d ? near_q : best_q[PL-1];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign hit_o               = hit_q;
  assign new_best_distance_o = nbd_q;

  `RBST_ASSERT(a_ready_follows_output, in_ready_o == (!out_valid_o || out_ready_i))
  `RBST_ASSERT(a_accept_enters_pipe, (in_valid_i && in_ready_o) |=> v_q[0])
  `RBST_ASSERT(a_stall_freezes_tail, !adv |=> ($stable(v_q[PL-1]) && $stable(nbd_q)))
  `RBST_ASSERT_ALWAYS(a_no_output_in_reset, !rst_ni |=> !out_valid_o)
endmodule
`default_nettype wire
